### hdl/lossy_loopback_link_emulator_assert.svh
// Assertion macros for the checker of the loopback link emulator.
// Needs nothing but a clock and an active-low reset in the calling scope's ports.
`ifndef LOSSY_LOOPBACK_LINK_EMULATOR_ASSERT_SVH
`define LOSSY_LOOPBACK_LINK_EMULATOR_ASSERT_SVH

// same-cycle implication
`define LLLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("llle check failed");

// next-cycle implication
`define LLLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("llle check failed");

`endif

### hdl/llle_pkg.sv
// Shared types, codes and defaults of the loopback link emulator.
// No dependencies.
package llle_pkg;

    localparam int QUEUE_DEPTH_DEF      = 16;
    localparam int MAX_PACKET_BYTES_DEF = 1024;
    localparam int MOD_STEPS            = 32;   // one quotient bit per step

    localparam logic [2:0] CMD_SEND  = 3'd0;
    localparam logic [2:0] CMD_POLL  = 3'd1;
    localparam logic [2:0] CMD_RECV  = 3'd2;
    localparam logic [2:0] CMD_CLOSE = 3'd3;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DISC  = 3'd1;
    localparam logic [2:0] ST_BIG   = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    localparam logic [1:0] REG_DROP  = 2'd0;
    localparam logic [1:0] REG_REORD = 2'd1;
    localparam logic [1:0] REG_DUP   = 2'd2;
    localparam logic [1:0] REG_DELAY = 2'd3;

    typedef struct packed {
        logic done;
        logic zero;
    } t_mod_res;

endpackage

### hdl/lossy_loopback_link_emulator.sv
// Loopback link emulator with drop / reorder / duplicate / delay fault injection.
// Usage: requests enter on s_axis_*: tuser holds command[2:0] and endpoint[3],
//   tdata holds packet_tag[15:0] and packet_length[31:16].
//   One result per request leaves on m_axis_*: tuser holds status[2:0],
//   packet_valid[3], connected[4]; tdata holds out_tag[15:0], out_length[31:16].
//   Registers are written on the cfg channel (index 0 drop, 1 reorder,
//   2 duplicate period, 3 delay polls). The user must write them only while
//   no request is in flight; the block itself does not enforce this.
// Flow, set by the state walk: a send runs the 32-step serial remainder units
//   that test the periods, then pushes (an extra move for a reorder, an extra
//   push for a duplicate, nothing when dropped); a poll does one RAM read and
//   one write-back per waiting entry; a receive reads the delivery queue head.
// One request is worked on at a time; the next is accepted in the cycle after
// the result is registered.
// Reset (synchronous, i_rst_n low): both sides open, counters and queues
// empty, registers zero. Queue RAMs are not cleared; fill counts guard them.
// A stalled receiver holds the result in the output register; the engine
// takes the next request and parks after it until that register frees up.
// Depends on llle_pkg, llle_ram, llle_mod.
module lossy_loopback_link_emulator #(
    parameter int QUEUE_DEPTH      = llle_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_PACKET_BYTES = llle_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // packet_tag[15:0], packet_length[31:16]
    input  logic [3:0]  s_axis_tuser,   // command[2:0], endpoint[3]
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_tag[15:0], out_length[31:16]
    output logic [4:0]  m_axis_tuser,   // status[2:0], packet_valid[3], connected[4]
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import llle_pkg::*;

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;  // queue pointer
    localparam int FW = $clog2(QUEUE_DEPTH + 1);                      // fill count
    localparam int AW = $clog2(2 * QUEUE_DEPTH);                      // RAM address

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_DISP = 10'b0000000010,
        S_MOD  = 10'b0000000100,
        S_PUSH = 10'b0000001000,
        S_PMV  = 10'b0000010000,
        S_PIN  = 10'b0000100000,
        S_PLRD = 10'b0001000000,
        S_PLWB = 10'b0010000000,
        S_RX   = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    function automatic logic [AW-1:0] f_addr(input logic s, input logic [QW-1:0] p);
        f_addr = s ? AW'(QUEUE_DEPTH) + AW'(p) : AW'(p);
    endfunction

    function automatic logic [QW-1:0] f_inc(input logic [QW-1:0] p);
        f_inc = (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [QW-1:0] f_dec(input logic [QW-1:0] p);
        f_dec = (p == '0) ? QW'(QUEUE_DEPTH - 1) : p - 1'b1;
    endfunction

    function automatic logic [QW-1:0] f_tail(input logic [QW-1:0] h, input logic [FW-1:0] f);
        logic [QW:0] sum;
        sum = {1'b0, h} + (QW+1)'(f);
        if (sum >= (QW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (QW+1)'(QUEUE_DEPTH);
        end
        f_tail = sum[QW-1:0];
    endfunction

    t_state      r_state;
    logic [2:0]  r_cmd;
    logic        r_ep;
    logic [15:0] r_tag;
    logic [15:0] r_len;
    logic        r_open [2];
    logic [31:0] r_sends [2];
    logic [QW-1:0] r_wh [2];
    logic [FW-1:0] r_wf [2];
    logic [QW-1:0] r_dh [2];
    logic [FW-1:0] r_df [2];
    logic [15:0] r_drop_per;
    logic [15:0] r_reord_per;
    logic [15:0] r_dup_per;
    logic [7:0]  r_delay;
    logic [2:0]  r_status;
    logic        r_full;
    logic        r_side;
    logic        r_to_wait;
    logic        r_before;
    logic        r_dup;
    logic [QW-1:0] r_pos;
    logic [FW-1:0] r_left;
    logic        r_prefix;
    logic        r_pv;
    logic [15:0] r_otag;
    logic [15:0] r_olen;
    logic        r_m_valid;
    logic [31:0] r_m_data;
    logic [4:0]  r_m_user;

    // RAM ports
    logic          w_we, w_re, d_we, d_re;
    logic [AW-1:0] w_waddr, w_raddr, d_waddr, d_raddr;
    logic [39:0]   w_wdata, w_rdata;   // countdown[39:32], length[31:16], tag[15:0]
    logic [31:0]   d_wdata, d_rdata;   // length[31:16], tag[15:0]

    // remainder units
    logic        mod_start;
    logic [31:0] cnt_next;
    t_mod_res    res_drop, res_reord, res_dup;
    logic        hit_drop, hit_reord, hit_dup;

    // selected queue for pushes
    logic [FW-1:0] sel_f;
    logic [QW-1:0] sel_h, sel_tail, sel_last;
    logic          push_full;
    logic [QW-1:0] dtail;
    logic          d_room;
    logic [7:0]    cd_next;
    logic          release_hd;
    logic          send_ok;
    logic          out_go;

    assign cnt_next  = r_sends[r_ep] + 32'd1;
    assign send_ok   = r_open[0] && r_open[1] &&
                       ({1'b0, r_len} <= 17'(MAX_PACKET_BYTES));
    assign mod_start = (r_state == S_DISP) && (r_cmd == CMD_SEND) && send_ok;

    llle_mod u_mod_drop (.i_clk, .i_rst_n, .i_start(mod_start), .i_dividend(cnt_next),
                         .i_divisor(r_drop_per), .o_res(res_drop));
    llle_mod u_mod_reord (.i_clk, .i_rst_n, .i_start(mod_start), .i_dividend(cnt_next),
                          .i_divisor(r_reord_per), .o_res(res_reord));
    llle_mod u_mod_dup (.i_clk, .i_rst_n, .i_start(mod_start), .i_dividend(cnt_next),
                        .i_divisor(r_dup_per), .o_res(res_dup));

    assign hit_drop  = (r_drop_per  != '0) && res_drop.zero;
    assign hit_reord = (r_reord_per != '0) && res_reord.zero;
    assign hit_dup   = (r_dup_per   != '0) && res_dup.zero;

    llle_ram #(.WIDTH(40), .DEPTH(2 * QUEUE_DEPTH), .AW(AW)) u_wait_ram (
        .i_clk, .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_re(w_re), .i_raddr(w_raddr), .o_rdata(w_rdata));

    llle_ram #(.WIDTH(32), .DEPTH(2 * QUEUE_DEPTH), .AW(AW)) u_dlv_ram (
        .i_clk, .i_we(d_we), .i_waddr(d_waddr), .i_wdata(d_wdata),
        .i_re(d_re), .i_raddr(d_raddr), .o_rdata(d_rdata));

    assign sel_f     = r_to_wait ? r_wf[r_side] : r_df[r_side];
    assign sel_h     = r_to_wait ? r_wh[r_side] : r_dh[r_side];
    assign sel_tail  = f_tail(sel_h, sel_f);
    assign sel_last  = f_dec(sel_tail);
    assign push_full = (sel_f == FW'(QUEUE_DEPTH));
    assign dtail     = f_tail(r_dh[r_side], r_df[r_side]);
    assign d_room    = (r_df[r_side] != FW'(QUEUE_DEPTH));
    assign cd_next   = (w_rdata[39:32] == '0) ? '0 : w_rdata[39:32] - 8'd1;
    assign release_hd = r_prefix && (cd_next == '0);
    assign out_go    = !r_m_valid || m_axis_tready;

    // RAM access per state
    always_comb begin
        w_we = 1'b0; w_waddr = '0; w_wdata = '0; w_re = 1'b0; w_raddr = '0;
        d_we = 1'b0; d_waddr = '0; d_wdata = '0; d_re = 1'b0; d_raddr = '0;
        unique case (r_state)
            S_DISP: begin
                d_re    = (r_cmd == CMD_RECV);
                d_raddr = f_addr(r_ep, r_dh[r_ep]);
            end
            S_PUSH: begin
                if (!push_full) begin
                    if (r_before && sel_f != '0) begin
                        // insert before last: fetch the current last entry first
                        w_re    = r_to_wait;
                        d_re    = !r_to_wait;
                        w_raddr = f_addr(r_side, sel_last);
                        d_raddr = f_addr(r_side, sel_last);
                    end else begin
                        w_we = r_to_wait;
                        d_we = !r_to_wait;
                    end
                end
                w_waddr = f_addr(r_side, sel_tail);
                d_waddr = f_addr(r_side, sel_tail);
                w_wdata = {r_delay, r_len, r_tag};
                d_wdata = {r_len, r_tag};
            end
            S_PMV: begin
                w_we    = r_to_wait;
                d_we    = !r_to_wait;
                w_waddr = f_addr(r_side, sel_tail);
                d_waddr = f_addr(r_side, sel_tail);
                w_wdata = w_rdata;
                d_wdata = d_rdata;
            end
            S_PIN: begin
                w_we    = r_to_wait;
                d_we    = !r_to_wait;
                w_waddr = f_addr(r_side, sel_last);
                d_waddr = f_addr(r_side, sel_last);
                w_wdata = {r_delay, r_len, r_tag};
                d_wdata = {r_len, r_tag};
            end
            S_PLRD: begin
                w_re    = (r_left != '0);
                w_raddr = f_addr(r_side, r_pos);
            end
            S_PLWB: begin
                if (release_hd) begin
                    d_we = d_room;
                end else begin
                    w_we = 1'b1;
                end
                d_waddr = f_addr(r_side, dtail);
                d_wdata = w_rdata[31:0];
                w_waddr = f_addr(r_side, r_pos);
                w_wdata = {cd_next, w_rdata[31:0]};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_open[0]   <= 1'b1;
            r_open[1]   <= 1'b1;
            r_sends[0]  <= '0;
            r_sends[1]  <= '0;
            r_wh[0] <= '0; r_wh[1] <= '0; r_wf[0] <= '0; r_wf[1] <= '0;
            r_dh[0] <= '0; r_dh[1] <= '0; r_df[0] <= '0; r_df[1] <= '0;
            r_drop_per  <= '0;
            r_reord_per <= '0;
            r_dup_per   <= '0;
            r_delay     <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_DROP:  r_drop_per  <= i_cfg_data;
                    REG_REORD: r_reord_per <= i_cfg_data;
                    REG_DUP:   r_dup_per   <= i_cfg_data;
                    REG_DELAY: r_delay     <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            // output register: loaded when a result is ready, freed on accept
            if (r_state == S_OUT && out_go) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd    <= s_axis_tuser[2:0];
                        r_ep     <= s_axis_tuser[3];
                        r_tag    <= s_axis_tdata[15:0];
                        r_len    <= s_axis_tdata[31:16];
                        r_status <= ST_OK;
                        r_pv     <= 1'b0;
                        r_otag   <= '0;
                        r_olen   <= '0;
                        r_full   <= 1'b0;
                        r_state  <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_state <= S_OUT;
                    unique case (r_cmd)
                        CMD_SEND: begin
                            if (!(r_open[0] && r_open[1])) begin
                                r_status <= ST_DISC;
                            end else if (!send_ok) begin
                                r_status <= ST_BIG;
                            end else begin
                                r_sends[r_ep] <= cnt_next;
                                r_side        <= ~r_ep;
                                r_to_wait     <= (r_delay != '0);
                                r_state       <= S_MOD;
                            end
                        end
                        CMD_POLL: begin
                            if (r_open[r_ep]) begin
                                r_side   <= r_ep;
                                r_pos    <= r_wh[r_ep];
                                r_left   <= r_wf[r_ep];
                                r_prefix <= 1'b1;
                                r_state  <= S_PLRD;
                            end
                        end
                        CMD_RECV: begin
                            if (!r_open[r_ep] || r_df[r_ep] == '0) begin
                                r_status <= ST_EMPTY;
                            end else begin
                                r_side  <= r_ep;
                                r_state <= S_RX;
                            end
                        end
                        CMD_CLOSE: begin
                            r_open[r_ep] <= 1'b0;
                            r_wf[r_ep]   <= '0;
                            r_df[r_ep]   <= '0;
                        end
                        default: begin
                        end
                    endcase
                end
                S_MOD: begin
                    if (res_drop.done) begin
                        if (hit_drop) begin
                            r_state <= S_OUT;
                        end else begin
                            r_before <= hit_reord;
                            r_dup    <= hit_dup;
                            r_state  <= S_PUSH;
                        end
                    end
                end
                S_PUSH: begin
                    if (!push_full && r_before && sel_f != '0) begin
                        r_state <= S_PMV;
                    end else begin
                        if (push_full) begin
                            r_full <= 1'b1;
                        end else if (r_to_wait) begin
                            r_wf[r_side] <= r_wf[r_side] + 1'b1;
                        end else begin
                            r_df[r_side] <= r_df[r_side] + 1'b1;
                        end
                        r_before <= 1'b0;
                        r_dup    <= 1'b0;
                        r_state  <= r_dup ? S_PUSH : S_OUT;
                    end
                end
                S_PMV: begin
                    r_state <= S_PIN;
                end
                S_PIN: begin
                    if (r_to_wait) begin
                        r_wf[r_side] <= r_wf[r_side] + 1'b1;
                    end else begin
                        r_df[r_side] <= r_df[r_side] + 1'b1;
                    end
                    r_before <= 1'b0;
                    r_dup    <= 1'b0;
                    r_state  <= r_dup ? S_PUSH : S_OUT;
                end
                S_PLRD: begin
                    r_state <= (r_left == '0) ? S_OUT : S_PLWB;
                end
                S_PLWB: begin
                    if (release_hd) begin
                        // expired head leaves the wait queue even when dropped
                        if (d_room) begin
                            r_df[r_side] <= r_df[r_side] + 1'b1;
                        end else begin
                            r_full <= 1'b1;
                        end
                        r_wh[r_side] <= f_inc(r_wh[r_side]);
                        r_wf[r_side] <= r_wf[r_side] - 1'b1;
                    end else begin
                        r_prefix <= 1'b0;
                    end
                    r_pos   <= f_inc(r_pos);
                    r_left  <= r_left - 1'b1;
                    r_state <= S_PLRD;
                end
                S_RX: begin
                    r_pv         <= 1'b1;
                    r_otag       <= d_rdata[15:0];
                    r_olen       <= d_rdata[31:16];
                    r_dh[r_side] <= f_inc(r_dh[r_side]);
                    r_df[r_side] <= r_df[r_side] - 1'b1;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    if (out_go) begin
                        r_m_data  <= {r_olen, r_otag};
                        r_m_user  <= {r_open[0] && r_open[1], r_pv,
                                      r_full ? ST_FULL : r_status};
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign o_cfg_ready   = 1'b1;
endmodule

### hdl/llle_ram.sv
// Simple dual-port synchronous RAM with a registered read.
// No dependencies.
module llle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/llle_mod.sv
// Bit-serial remainder unit: reports whether a 32-bit count is a multiple of a period.
// Depends on llle_pkg.
module llle_mod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [31:0]       i_dividend,
    input  logic [15:0]       i_divisor,
    output llle_pkg::t_mod_res o_res
);
    import llle_pkg::*;

    localparam int CW = $clog2(MOD_STEPS);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [31:0]   r_q;
    logic [15:0]   r_d;
    logic [15:0]   r_rem;
    logic [16:0]   trial;

    assign trial = {r_rem, r_q[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_q    <= i_dividend;
            r_d    <= i_divisor;
            r_rem  <= '0;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_d}) begin
                r_rem <= 16'(trial - {1'b0, r_d});
            end else begin
                r_rem <= trial[15:0];
            end
            r_q   <= {r_q[30:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(MOD_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.zero = (r_rem == '0);
endmodule

### hdl/llle_check.sv
// Port-level checker for the loopback link emulator, bound to the top level.
// Depends on llle_pkg and lossy_loopback_link_emulator_assert.svh.
`include "lossy_loopback_link_emulator_assert.svh"

module llle_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [4:0]  m_axis_tuser
);
    import llle_pkg::*;

    // a returned packet always comes with ok status
    `LLLE_ASSERT_NOW(a_pkt_ok, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[3],
        m_axis_tuser[2:0] == ST_OK)
    // no packet, no payload
    `LLLE_ASSERT_NOW(a_no_pkt_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[3],
        m_axis_tdata == '0)
    // status codes stay in the defined set
    `LLLE_ASSERT_NOW(a_status_range, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tuser[2:0] == ST_OK || m_axis_tuser[2:0] == ST_DISC ||
        m_axis_tuser[2:0] == ST_BIG || m_axis_tuser[2:0] == ST_FULL ||
        m_axis_tuser[2:0] == ST_EMPTY)
    // a closed link stays closed until reset
    `LLLE_ASSERT_NEXT(a_link_stays_down, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tuser[4], !(m_axis_tvalid && m_axis_tuser[4]))
    // a stalled result holds still
    `LLLE_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
endmodule

bind lossy_loopback_link_emulator llle_check u_llle_check (.*);

### dv/lossy_loopback_link_emulator_test.sv
// Self-checking bench for the lossy loopback link emulator: random and directed
// requests, an in-bench link model predicting every result. Depends on llle_pkg.
module lossy_loopback_link_emulator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import llle_pkg::*;

    localparam int QD = QUEUE_DEPTH_DEF;
    localparam int MAXB = MAX_PACKET_BYTES_DEF;
    localparam logic [2:0] CMD_QUERY   = 3'd4;
    localparam logic [2:0] CMD_RSVD_LO = 3'd5;
    localparam logic [2:0] CMD_RSVD_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        ep;
        logic [15:0] tag;
        logic [15:0] len;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic        pvalid;
        logic [15:0] tag;
        logic [15:0] len;
        logic        conn;
    } t_res;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 0;
    logic [3:0]  s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;
    logic [4:0]  m_axis_tuser;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 0;
    logic [15:0] i_cfg_data = 0;

    lossy_loopback_link_emulator DUT (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // ---------------- link model ----------------
    logic [15:0] m_drop, m_reord, m_dup;
    logic [7:0]  m_delay;
    logic        m_open [2];
    logic [31:0] m_sends [2];
    logic [15:0] w_tag [2][$];
    logic [15:0] w_len [2][$];
    logic [7:0]  w_cd  [2][$];
    logic [15:0] d_tag [2][$];
    logic [15:0] d_len [2][$];

    function automatic bit period_hit(logic [31:0] cnt, logic [15:0] per);
        return per != 0 && (cnt % per) == 0;
    endfunction

    function automatic bit push_deliver(int e, logic [15:0] t, logic [15:0] l, bit before_last);
        if (d_tag[e].size() >= QD) return 0;
        if (before_last && d_tag[e].size() > 0) begin
            d_tag[e].insert(d_tag[e].size() - 1, t);
            d_len[e].insert(d_len[e].size() - 1, l);
        end else begin
            d_tag[e].insert(d_tag[e].size(), t);
            d_len[e].insert(d_len[e].size(), l);
        end
        return 1;
    endfunction

    function automatic bit push_wait(int e, logic [15:0] t, logic [15:0] l, bit before_last);
        if (w_tag[e].size() >= QD) return 0;
        if (before_last && w_tag[e].size() > 0) begin
            w_tag[e].insert(w_tag[e].size() - 1, t);
            w_len[e].insert(w_len[e].size() - 1, l);
            w_cd[e].insert(w_cd[e].size() - 1, m_delay);
        end else begin
            w_tag[e].insert(w_tag[e].size(), t);
            w_len[e].insert(w_len[e].size(), l);
            w_cd[e].insert(w_cd[e].size(), m_delay);
        end
        return 1;
    endfunction

    function automatic t_res link_predict(t_req r);
        t_res o;
        int e, p;
        bit ok, ro, du;
        logic [31:0] c;
        o = '0;
        e = int'(r.ep);
        p = 1 - e;
        o.status = ST_OK;
        case (r.cmd)
            CMD_SEND: begin
                if (!m_open[0] || !m_open[1]) o.status = ST_DISC;
                else if (r.len > MAXB) o.status = ST_BIG;
                else begin
                    c = m_sends[e] + 32'd1;
                    m_sends[e] = c;
                    if (!period_hit(c, m_drop)) begin
                        ro = period_hit(c, m_reord);
                        du = period_hit(c, m_dup);
                        if (m_delay == 0) begin
                            ok = push_deliver(p, r.tag, r.len, ro);
                            if (du) ok = push_deliver(p, r.tag, r.len, 0) && ok;
                        end else begin
                            ok = push_wait(p, r.tag, r.len, ro);
                            if (du) ok = push_wait(p, r.tag, r.len, 0) && ok;
                        end
                        if (!ok) o.status = ST_FULL;
                    end
                end
            end
            CMD_POLL: if (m_open[e]) begin
                ok = 1;
                for (int i = 0; i < w_cd[e].size(); i++)
                    if (w_cd[e][i] != 0) w_cd[e][i]--;
                while (w_tag[e].size() > 0 && w_cd[e][0] == 0) begin
                    if (!push_deliver(e, w_tag[e][0], w_len[e][0], 0)) ok = 0;
                    w_tag[e].delete(0);
                    w_len[e].delete(0);
                    w_cd[e].delete(0);
                end
                if (!ok) o.status = ST_FULL;
            end
            CMD_RECV: begin
                if (!m_open[e] || d_tag[e].size() == 0) o.status = ST_EMPTY;
                else begin
                    o.pvalid = 1;
                    o.tag = d_tag[e][0];
                    o.len = d_len[e][0];
                    d_tag[e].delete(0);
                    d_len[e].delete(0);
                end
            end
            CMD_CLOSE: begin
                m_open[e] = 0;
                w_tag[e].delete(); w_len[e].delete(); w_cd[e].delete();
                d_tag[e].delete(); d_len[e].delete();
            end
            default: ;
        endcase
        o.conn = m_open[0] && m_open[1];
        return o;
    endfunction

    task automatic link_model_reset();
        m_drop = 0; m_reord = 0; m_dup = 0; m_delay = 0;
        for (int e = 0; e < 2; e++) begin
            m_open[e] = 1;
            m_sends[e] = 0;
            w_tag[e].delete(); w_len[e].delete(); w_cd[e].delete();
            d_tag[e].delete(); d_len[e].delete();
        end
    endtask

    // ---------------- queues, knobs ----------------
    t_req pending_reqs [$];
    t_res expected_results [$];
    int   send_idle_pct = 30;
    int   recv_idle_pct = 85;
    int   errors = 0;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic queue_req(t_req r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // driver: one request is taken and predicted when it is accepted
    always @(posedge i_clk) begin
        t_req r;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                r = pending_reqs[0];
                pending_reqs.delete(0);
                expected_results.insert(expected_results.size(), link_predict(r));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    r = pending_reqs[0];
                    s_axis_tvalid <= 1;
                    s_axis_tuser  <= {r.ep, r.cmd};
                    s_axis_tdata  <= {r.len, r.tag};
                end else begin
                    s_axis_tvalid <= 0;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        t_res w;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 32'(m_axis_tuser), 32'd0);
                end else begin
                    w = expected_results[0];
                    expected_results.delete(0);
                    if (m_axis_tuser[2:0] != w.status)
                        report_mismatch("status", 32'(m_axis_tuser[2:0]), 32'(w.status));
                    if (m_axis_tuser[3] != w.pvalid)
                        report_mismatch("packet_valid", 32'(m_axis_tuser[3]), 32'(w.pvalid));
                    if (m_axis_tuser[4] != w.conn)
                        report_mismatch("connected", 32'(m_axis_tuser[4]), 32'(w.conn));
                    if (m_axis_tdata[15:0] != w.tag)
                        report_mismatch("out_tag", 32'(m_axis_tdata[15:0]), 32'(w.tag));
                    if (m_axis_tdata[31:16] != w.len)
                        report_mismatch("out_length", 32'(m_axis_tdata[31:16]), 32'(w.len));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------- stimulus helpers ----------------
    function automatic t_req mk(logic [2:0] c, logic e, logic [15:0] t, logic [15:0] l);
        t_req r;
        r.cmd = c; r.ep = e; r.tag = t; r.len = l;
        return r;
    endfunction

    // wait for every queued request to be accepted and answered, then let
    // the engine settle
    task automatic drain();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        case (idx)
            REG_DROP:  m_drop  = val;
            REG_REORD: m_reord = val;
            REG_DUP:   m_dup   = val;
            REG_DELAY: m_delay = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_faults(logic [15:0] d, logic [15:0] ro, logic [15:0] du, logic [7:0] dl);
        drain();
        write_reg(REG_DROP, d);
        write_reg(REG_REORD, ro);
        write_reg(REG_DUP, du);
        write_reg(REG_DELAY, {8'h00, dl});
    endtask

    // mostly sends and polls/receives; length mostly legal
    function automatic t_req rand_req();
        int k;
        logic [15:0] l;
        logic e;
        k = $urandom_range(99);
        e = 1'($urandom_range(1));
        l = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(MAXB));
        if (k < 45) return mk(CMD_SEND, e, 16'($urandom), l);
        if (k < 65) return mk(CMD_POLL, e, 16'($urandom), 16'($urandom));
        if (k < 96) return mk(CMD_RECV, e, 16'($urandom), 16'($urandom));
        if (k < 98) return mk(CMD_QUERY, e, 16'($urandom), 16'($urandom));
        return mk(3'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO)), e,
                  16'($urandom), 16'($urandom));
    endfunction

    task automatic run_random(int n, bit allow_close);
        t_req r;
        for (int i = 0; i < n; i++) begin
            r = rand_req();
            if (allow_close && $urandom_range(199) == 0) r.cmd = CMD_CLOSE;
            queue_req(r);
            while (pending_reqs.size() > 8) @(posedge i_clk);
        end
    endtask

    // only reset reopens a side, so the closing tests run at the very end
    initial begin
        link_model_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, full queue, oversize
        queue_req(mk(CMD_RECV, 0, 0, 0));
        queue_req(mk(CMD_SEND, 0, 16'hFFFF, 16'(MAXB)));
        queue_req(mk(CMD_SEND, 1, 16'h0000, 0));
        queue_req(mk(CMD_SEND, 0, 16'h1234, 16'(MAXB + 1)));
        queue_req(mk(CMD_SEND, 0, 16'h5555, 16'hFFFF));
        queue_req(mk(CMD_RECV, 1, 0, 0));
        queue_req(mk(CMD_RECV, 0, 16'hFFFF, 16'hFFFF));
        queue_req(mk(CMD_QUERY, 1, 0, 0));
        queue_req(mk(CMD_RSVD_HI, 0, 16'hAAAA, 16'h5555));
        queue_req(mk(CMD_POLL, 1, 0, 0));
        for (int i = 0; i < 18; i++)
            queue_req(mk(CMD_SEND, 0, 16'(i), 16'(i)));
        drain();
        // pressure: everything answered before more
        for (int i = 0; i < 17; i++) queue_req(mk(CMD_RECV, 1, 0, 0));

        set_faults(2, 3, 5, 0);
        run_random(250, 0);
        set_faults(1, 0, 0, 0);
        run_random(60, 0);
        set_faults(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        run_random(80, 0);
        set_faults(0, 2, 3, 1);
        run_random(300, 0);

        send_idle_pct = 85; recv_idle_pct = 30;
        set_faults(7, 1, 4, 3);
        run_random(300, 0);
        set_faults(0, 0, 1, 2);
        run_random(300, 0);

        send_idle_pct = 0; recv_idle_pct = 0;
        set_faults(0, 5, 2, 0);
        run_random(300, 0);
        set_faults(11, 4, 6, 2);
        run_random(200, 1);
        queue_req(mk(CMD_CLOSE, 1, 0, 0));
        queue_req(mk(CMD_CLOSE, 1, 0, 0));
        queue_req(mk(CMD_SEND, 0, 1, 1));
        queue_req(mk(CMD_POLL, 1, 0, 0));
        queue_req(mk(CMD_RECV, 1, 0, 0));
        queue_req(mk(CMD_QUERY, 0, 0, 0));
        run_random(40, 1);
        drain();

        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
